/* src/dvrt_pkg.sv */
// ----------------------------------------------------------------------------
// Distance-vector route table package
// Shared types and codes for the route table.
// ----------------------------------------------------------------------------
package dvrt_pkg;

    localparam int unsigned MAX_RESULTS = 32;
    localparam logic [31:0] FULL_MASK   = 32'hFFFF_FFFF;
    localparam logic [4:0]  UNREACHABLE = 5'd16;
    localparam logic [15:0] AGE_MAX     = 16'hFFFF;

    typedef enum logic [2:0] {
        KIND_RECV   = 3'd0,
        KIND_TICK   = 3'd1,
        KIND_ADV    = 3'd2,
        KIND_LOOKUP = 3'd3,
        KIND_ADD    = 3'd4,
        KIND_REMOVE = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_INSERTED = 3'd1,
        ST_IMPROVED = 3'd2,
        ST_IGNORED  = 3'd3,
        ST_FULL     = 3'd4,
        ST_NOTFOUND = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        REG_IFACE0  = 3'd0,
        REG_IFACE1  = 3'd1,
        REG_IFACE2  = 3'd2,
        REG_IFACE3  = 3'd3,
        REG_ICOUNT  = 3'd4,
        REG_TIMEOUT = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] mask;
        logic [4:0]  cost;
        logic [31:0] hop;
        logic [15:0] age;
    } entry_t;

endpackage

/* src/distance_vector_route_table_top.sv */
// ----------------------------------------------------------------------------
// Distance-vector route table
// Route table with learning, aging, poison-reverse advertising and lookup.
// ----------------------------------------------------------------------------
// An item is transferred on a rising edge with start high and busy low.
// Each result appears for one cycle with done high; last marks the final
// result of an item. The receiver cannot stall, so results are never held.
// Registers are written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. The user must make writes only while
// idle; the block itself does not enforce it. Route fields live in one
// synchronous memory with a registered read. Each table operation but an
// advertise sweeps the memory once, with the result registered in S_FIN
// after the sweep. An ignored received entry or an unused kind is answered
// from the idle state without a sweep. An advertise runs one sweep per
// listed route to find the next higher address and yields one route per
// sweep. Reset clears all valid bits and registers; the memory contents
// need no clearing.
// ----------------------------------------------------------------------------
module distance_vector_route_table_top #(
    parameter int TABLE_DEPTH = 32,
    parameter int NUM_IFACES  = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            kind,
    input  logic [31:0]           dest_addr,
    input  logic [31:0]           dest_mask,
    input  logic [4:0]            route_cost,
    input  logic [31:0]           peer_addr,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    output logic                  done,
    output logic [31:0]           out_addr,
    output logic [31:0]           out_mask,
    output logic [4:0]            out_cost,
    output logic                  entry_valid,
    output logic [31:0]           route_hop,
    output logic [2:0]            status,
    output logic                  last
);
    import dvrt_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1) + 1;
    localparam int KW = $clog2(MAX_RESULTS + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
    localparam logic [KW-1:0] MAX_C = KW'(MAX_RESULTS);
    localparam logic [2:0] NIF_C = 3'(NUM_IFACES);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FIN  = 4'b0100,
        S_TAIL = 4'b1000
    } state_t;

    state_t state_reg;
    logic [31:0] iface_reg [4];
    logic [2:0]  icount_reg;
    logic [15:0] timeout_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_reg;
    logic   we;
    logic [IW-1:0] wa;
    entry_t wd;

    logic [2:0]  kind_reg;
    logic [31:0] dest_reg, mask_reg, peer_reg;
    logic [4:0]  cost_reg;
    logic [CW-1:0] cnt_reg;
    logic pv_reg;
    logic [IW-1:0] pidx_reg;
    logic found_reg;
    logic [IW-1:0] fidx_reg;
    logic [4:0]  fcost_reg;
    logic [31:0] fhop_reg;
    logic bf_reg;
    entry_t best_reg;
    logic pend_reg;
    entry_t pend_reg_e;
    logic have_prev_reg;
    logic [31:0] prev_reg;
    logic [KW-1:0] kcnt_reg;

    logic [2:0] n_if;
    logic in_local, rd_local;
    logic free_any;
    logic [IW-1:0] free_idx;
    logic rv;
    logic [15:0] age_inc;
    logic [4:0] cost_p1;
    logic [4:0] pend_cost;

    assign n_if = (icount_reg > NIF_C) ? NIF_C : icount_reg;
    assign cfg_ready = 1'b1;
    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        in_local = 1'b0;
        rd_local = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) < n_if && iface_reg[i] == dest_addr)
                in_local = 1'b1;
            if (3'(i) < n_if && iface_reg[i] == rd_reg.dest)
                rd_local = 1'b1;
        end
    end

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign rv = pv_reg && valid_reg[pidx_reg];
    assign age_inc = (rd_reg.age == AGE_MAX) ? rd_reg.age : rd_reg.age + 16'd1;
    assign cost_p1 = cost_reg + 5'd1;
    assign pend_cost = (pend_reg_e.dest != peer_reg && pend_reg_e.hop == peer_reg)
                       ? UNREACHABLE : pend_reg_e.cost;

    always_comb
    begin
        we = 1'b0;
        wa = pidx_reg;
        wd = rd_reg;
        if (state_reg == S_SCAN && kind_reg == KIND_TICK && rv)
        begin
            we = 1'b1;
            wd.age = age_inc;
        end
        else if (state_reg == S_FIN)
        begin
            wa = found_reg ? fidx_reg : free_idx;
            if (kind_reg == KIND_RECV)
            begin
                wd = '{dest: dest_reg, mask: mask_reg, cost: cost_p1, hop: peer_reg, age: '0};
                we = found_reg ? (fcost_reg > cost_p1) : free_any;
            end
            else if (kind_reg == KIND_ADD)
            begin
                wd = '{dest: dest_reg, mask: FULL_MASK, cost: '0, hop: dest_reg, age: '0};
                we = found_reg || free_any;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_reg <= mem[cnt_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < 4; i++)
                iface_reg[i] <= '0;
            icount_reg <= '0;
            timeout_reg <= 16'd12;
            valid_reg <= '0;
            done <= 1'b0;
            out_addr <= '0;
            out_mask <= '0;
            out_cost <= '0;
            entry_valid <= 1'b0;
            route_hop <= '0;
            status <= '0;
            last <= 1'b0;
            kind_reg <= '0;
            dest_reg <= '0;
            mask_reg <= '0;
            peer_reg <= '0;
            cost_reg <= '0;
            cnt_reg <= '0;
            pv_reg <= 1'b0;
            pidx_reg <= '0;
            found_reg <= 1'b0;
            fidx_reg <= '0;
            fcost_reg <= '0;
            fhop_reg <= '0;
            bf_reg <= 1'b0;
            best_reg <= '0;
            pend_reg <= 1'b0;
            pend_reg_e <= '0;
            have_prev_reg <= 1'b0;
            prev_reg <= '0;
            kcnt_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_IFACE0: iface_reg[0] <= cfg_data;
                    REG_IFACE1: iface_reg[1] <= cfg_data;
                    REG_IFACE2: iface_reg[2] <= cfg_data;
                    REG_IFACE3: iface_reg[3] <= cfg_data;
                    REG_ICOUNT: icount_reg <= cfg_data[2:0];
                    REG_TIMEOUT: timeout_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (we && state_reg == S_FIN)
                valid_reg[wa] <= 1'b1;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg <= kind;
                        dest_reg <= dest_addr;
                        mask_reg <= dest_mask;
                        cost_reg <= route_cost;
                        peer_reg <= peer_addr;
                        cnt_reg <= '0;
                        pv_reg <= 1'b0;
                        found_reg <= 1'b0;
                        bf_reg <= 1'b0;
                        pend_reg <= 1'b0;
                        have_prev_reg <= 1'b0;
                        kcnt_reg <= '0;
                        if (kind > KIND_REMOVE ||
                            (kind == KIND_RECV && (in_local || route_cost >= UNREACHABLE)))
                        begin
                            done <= 1'b1;
                            out_addr <= '0;
                            out_mask <= '0;
                            out_cost <= '0;
                            entry_valid <= 1'b0;
                            route_hop <= '0;
                            status <= ST_IGNORED;
                            last <= 1'b1;
                        end
                        else
                            state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (cnt_reg < DEPTH_C)
                    begin
                        pv_reg <= 1'b1;
                        pidx_reg <= cnt_reg[IW-1:0];
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else
                        pv_reg <= 1'b0;
                    if (rv)
                    begin
                        case (kind_reg)
                            KIND_TICK:
                                if (!rd_local && age_inc > timeout_reg)
                                    valid_reg[pidx_reg] <= 1'b0;
                            KIND_REMOVE:
                                if (rd_reg.hop == dest_reg || rd_reg.dest == dest_reg)
                                    valid_reg[pidx_reg] <= 1'b0;
                            KIND_ADV:
                                if ((!have_prev_reg || rd_reg.dest > prev_reg) &&
                                    (!bf_reg || rd_reg.dest < best_reg.dest))
                                begin
                                    bf_reg <= 1'b1;
                                    best_reg <= rd_reg;
                                end
                            default:
                                if (!found_reg && rd_reg.dest == dest_reg)
                                begin
                                    found_reg <= 1'b1;
                                    fidx_reg <= pidx_reg;
                                    fcost_reg <= rd_reg.cost;
                                    fhop_reg <= rd_reg.hop;
                                end
                        endcase
                    end
                    if (pv_reg && pidx_reg == LAST_IDX)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    out_addr <= '0;
                    out_mask <= '0;
                    out_cost <= '0;
                    entry_valid <= 1'b0;
                    route_hop <= '0;
                    status <= ST_DONE;
                    last <= 1'b1;
                    done <= 1'b1;
                    state_reg <= S_IDLE;
                    case (kind_reg)
                        KIND_RECV:
                            status <= found_reg ? ((fcost_reg > cost_p1) ? ST_IMPROVED
                                                                          : ST_IGNORED)
                                                : (free_any ? ST_INSERTED : ST_FULL);
                        KIND_ADD:
                            status <= found_reg ? ST_IMPROVED
                                                : (free_any ? ST_INSERTED : ST_FULL);
                        KIND_LOOKUP:
                        begin
                            route_hop <= found_reg ? fhop_reg : '0;
                            status <= found_reg ? ST_DONE : ST_NOTFOUND;
                        end
                        KIND_ADV:
                        begin
                            if (pend_reg)
                            begin
                                out_addr <= pend_reg_e.dest;
                                out_mask <= pend_reg_e.mask;
                                out_cost <= pend_cost;
                                entry_valid <= 1'b1;
                            end
                            done <= pend_reg || !bf_reg;
                            if (bf_reg)
                            begin
                                last <= 1'b0;
                                pend_reg <= 1'b1;
                                pend_reg_e <= best_reg;
                                have_prev_reg <= 1'b1;
                                prev_reg <= best_reg.dest;
                                kcnt_reg <= kcnt_reg + 1'b1;
                                cnt_reg <= '0;
                                pv_reg <= 1'b0;
                                bf_reg <= 1'b0;
                                state_reg <= (kcnt_reg + 1'b1 == MAX_C) ? S_TAIL : S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
                S_TAIL:
                begin
                    done <= 1'b1;
                    out_addr <= pend_reg_e.dest;
                    out_mask <= pend_reg_e.mask;
                    out_cost <= pend_cost;
                    entry_valid <= 1'b1;
                    route_hop <= '0;
                    status <= ST_DONE;
                    last <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && kind == KIND_TICK |=> busy)
        else $error("tick did not start a sweep");
    a_adv_cost: assert property (@(posedge clk) disable iff (!rst_n)
        done && entry_valid |-> out_cost <= UNREACHABLE && status == ST_DONE)
        else $error("advertised route has a bad cost or status");
`endif

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// Route table testbench
// Drives received routes, ticks, advertisements, lookups and interface
// changes into the route table over several register settings and sender
// idle rates, and checks every result against a table kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
    import dvrt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] dest;
        logic [31:0] mask;
        logic [4:0]  cost;
        logic [31:0] peer;
    } update_t;

    typedef struct {
        logic [31:0] addr;
        logic [31:0] mask;
        logic [4:0]  cost;
        logic        valid;
        logic [31:0] hop;
        logic [2:0]  st;
        logic        last;
    } route_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  kind = '0;
    logic [31:0] dest_addr = '0;
    logic [31:0] dest_mask = '0;
    logic [4:0]  route_cost = '0;
    logic [31:0] peer_addr = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        done;
    logic [31:0] out_addr;
    logic [31:0] out_mask;
    logic [4:0]  out_cost;
    logic        entry_valid;
    logic [31:0] route_hop;
    logic [2:0]  status;
    logic        last;

    update_t     update_queue[$];
    route_row_t  route_results_due[$];
    int          idle_pct = 0;
    int          errors = 0;
    int          updates_sent = 0;
    int          results_seen = 0;
    int          routes_listed = 0;
    int          full_drops = 0;
    longint      cycles = 0;

    logic [31:0] iface_addr[4];
    logic [2:0]  iface_count;
    logic [15:0] timeout_ticks;
    bit          rt_valid[DEPTH];
    logic [31:0] rt_dest[DEPTH];
    logic [31:0] rt_mask[DEPTH];
    logic [4:0]  rt_cost[DEPTH];
    logic [31:0] rt_hop[DEPTH];
    logic [15:0] rt_age[DEPTH];
    logic [31:0] addr_pool[48];

    distance_vector_route_table_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .dest_addr(dest_addr), .dest_mask(dest_mask), .route_cost(route_cost),
        .peer_addr(peer_addr), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
        .out_addr(out_addr), .out_mask(out_mask), .out_cost(out_cost),
        .entry_valid(entry_valid), .route_hop(route_hop), .status(status),
        .last(last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit addr_is_local(logic [31:0] a);
        int n;
        n = (iface_count > 4) ? 4 : iface_count;
        for (int i = 0; i < n; i++)
            if (iface_addr[i] == a)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic int slot_of(logic [31:0] a);
        for (int i = 0; i < DEPTH; i++)
            if (rt_valid[i] && rt_dest[i] == a)
                return i;
        return -1;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < DEPTH; i++)
            if (!rt_valid[i])
                return i;
        return -1;
    endfunction

    task automatic store_route(int s, logic [31:0] d, logic [31:0] m, logic [4:0] c,
                               logic [31:0] h);
        rt_valid[s] = 1'b1;
        rt_dest[s] = d;
        rt_mask[s] = m;
        rt_cost[s] = c;
        rt_hop[s] = h;
        rt_age[s] = '0;
    endtask

    task automatic expect_status(status_t st);
        route_row_t r;
        r = '{addr: '0, mask: '0, cost: '0, valid: 1'b0, hop: '0, st: st, last: 1'b1};
        route_results_due.push_back(r);
    endtask

    task automatic predict_update(update_t u);
        int s;
        int k;
        int best;
        bit have_prev;
        logic [31:0] prev;
        route_row_t r;
        s = -1;
        k = 0;
        have_prev = 1'b0;
        prev = '0;
        case (u.kind)
            KIND_RECV:
            begin
                if (addr_is_local(u.dest) || u.cost >= UNREACHABLE)
                    expect_status(ST_IGNORED);
                else
                begin
                    s = slot_of(u.dest);
                    if (s < 0)
                    begin
                        s = free_slot();
                        if (s < 0)
                        begin
                            full_drops++;
                            expect_status(ST_FULL);
                        end
                        else
                        begin
                            store_route(s, u.dest, u.mask, u.cost + 5'd1, u.peer);
                            expect_status(ST_INSERTED);
                        end
                    end
                    else if ({1'b0, rt_cost[s]} > {1'b0, u.cost} + 6'd1)
                    begin
                        store_route(s, u.dest, u.mask, u.cost + 5'd1, u.peer);
                        expect_status(ST_IMPROVED);
                    end
                    else
                        expect_status(ST_IGNORED);
                end
            end
            KIND_TICK:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (rt_valid[i])
                    begin
                        if (rt_age[i] != AGE_MAX)
                            rt_age[i]++;
                        if (!addr_is_local(rt_dest[i]) && rt_age[i] > timeout_ticks)
                            rt_valid[i] = 1'b0;
                    end
                end
                expect_status(ST_DONE);
            end
            KIND_ADV:
            begin
                while (k < MAX_RESULTS)
                begin
                    best = -1;
                    for (int i = 0; i < DEPTH; i++)
                        if (rt_valid[i] && !(have_prev && rt_dest[i] <= prev))
                            if (best < 0 || rt_dest[i] < rt_dest[best])
                                best = i;
                    if (best < 0)
                        break;
                    r.addr = rt_dest[best];
                    r.mask = rt_mask[best];
                    r.cost = (rt_dest[best] != u.peer && rt_hop[best] == u.peer) ?
                             UNREACHABLE : rt_cost[best];
                    r.valid = 1'b1;
                    r.hop = '0;
                    r.st = ST_DONE;
                    r.last = 1'b0;
                    route_results_due.push_back(r);
                    prev = rt_dest[best];
                    have_prev = 1'b1;
                    k++;
                end
                if (k == 0)
                    expect_status(ST_DONE);
                else
                    route_results_due[route_results_due.size() - 1].last = 1'b1;
            end
            KIND_LOOKUP:
            begin
                s = slot_of(u.dest);
                if (s < 0)
                    expect_status(ST_NOTFOUND);
                else
                begin
                    r = '{addr: '0, mask: '0, cost: '0, valid: 1'b0, hop: rt_hop[s],
                          st: ST_DONE, last: 1'b1};
                    route_results_due.push_back(r);
                end
            end
            KIND_ADD:
            begin
                s = slot_of(u.dest);
                if (s >= 0)
                begin
                    store_route(s, u.dest, FULL_MASK, 5'd0, u.dest);
                    expect_status(ST_IMPROVED);
                end
                else
                begin
                    s = free_slot();
                    if (s < 0)
                    begin
                        full_drops++;
                        expect_status(ST_FULL);
                    end
                    else
                    begin
                        store_route(s, u.dest, FULL_MASK, 5'd0, u.dest);
                        expect_status(ST_INSERTED);
                    end
                end
            end
            KIND_REMOVE:
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (rt_valid[i] && (rt_hop[i] == u.dest || rt_dest[i] == u.dest))
                        rt_valid[i] = 1'b0;
                expect_status(ST_DONE);
            end
            default:
                expect_status(ST_IGNORED);
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want,
                 results_seen);
        errors++;
    endtask

    // Driver: a new transfer is offered once the previous one is taken.
    always @(posedge clk)
    begin
        update_t u;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                u = '{kind: kind, dest: dest_addr, mask: dest_mask, cost: route_cost,
                      peer: peer_addr};
                predict_update(u);
                updates_sent++;
            end
            if (!start || !busy)
            begin
                if (update_queue.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    u = update_queue.pop_front();
                    start <= 1'b1;
                    kind <= u.kind;
                    dest_addr <= u.dest;
                    dest_mask <= u.mask;
                    route_cost <= u.cost;
                    peer_addr <= u.peer;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IFACE0, REG_IFACE1, REG_IFACE2, REG_IFACE3:
                    iface_addr[cfg_index] = cfg_data;
                REG_ICOUNT:
                    iface_count = cfg_data[2:0];
                REG_TIMEOUT:
                    timeout_ticks = cfg_data[15:0];
                default:
                    ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        route_row_t r;
        if (rst_n && done)
        begin
            results_seen++;
            if (route_results_due.size() == 0)
                report_mismatch("unexpected result", {29'd0, status}, '0);
            else
            begin
                r = route_results_due.pop_front();
                if (out_addr !== r.addr)
                    report_mismatch("out_addr", out_addr, r.addr);
                if (out_mask !== r.mask)
                    report_mismatch("out_mask", out_mask, r.mask);
                if (out_cost !== r.cost)
                    report_mismatch("out_cost", out_cost, r.cost);
                if (entry_valid !== r.valid)
                    report_mismatch("entry_valid", entry_valid, r.valid);
                if (route_hop !== r.hop)
                    report_mismatch("route_hop", route_hop, r.hop);
                if (status !== r.st)
                    report_mismatch("status", status, r.st);
                if (last !== r.last)
                    report_mismatch("last", last, r.last);
                if (r.valid)
                    routes_listed++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench failed");
            $finish;
        end
    end

    task automatic queue_update(logic [2:0] k, logic [31:0] d, logic [31:0] m,
                                logic [4:0] c, logic [31:0] p);
        update_queue.push_back('{kind: k, dest: d, mask: m, cost: c, peer: p});
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [2:0] count, logic [15:0] tmo);
        write_reg(REG_IFACE0, addr_pool[0]);
        write_reg(REG_IFACE1, addr_pool[1]);
        write_reg(REG_IFACE2, addr_pool[2]);
        write_reg(REG_IFACE3, addr_pool[3]);
        write_reg(REG_ICOUNT, {29'd0, count});
        write_reg(REG_TIMEOUT, {16'd0, tmo});
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (update_queue.size() != 0 || start || busy || route_results_due.size() != 0);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_addr();
        if ($urandom_range(9) == 0)
            return $urandom;
        return addr_pool[$urandom_range(47)];
    endfunction

    task automatic queue_random(int n);
        int sel;
        logic [31:0] m;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            m = ($urandom_range(3) == 0) ? $urandom : FULL_MASK << $urandom_range(32);
            if (sel < 45)
                queue_update(KIND_RECV, pick_addr(), m,
                             ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(15)),
                             addr_pool[$urandom_range(7)]);
            else if (sel < 55)
                queue_update(KIND_TICK, $urandom, $urandom, 5'($urandom), $urandom);
            else if (sel < 65)
                queue_update(KIND_ADV, $urandom, $urandom, 5'($urandom),
                             ($urandom_range(4) == 0) ? pick_addr() :
                             addr_pool[$urandom_range(7)]);
            else if (sel < 82)
                queue_update(KIND_LOOKUP, pick_addr(), $urandom, 5'($urandom), $urandom);
            else if (sel < 89)
                queue_update(KIND_ADD, pick_addr(), $urandom, 5'($urandom), $urandom);
            else if (sel < 96)
                queue_update(KIND_REMOVE, pick_addr(), $urandom, 5'($urandom), $urandom);
            else
                queue_update(3'($urandom_range(7, 6)), $urandom, $urandom, 5'($urandom),
                             $urandom);
        end
    endtask

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            rt_valid[i] = 1'b0;
        for (int i = 0; i < 4; i++)
            iface_addr[i] = '0;
        iface_count = '0;
        timeout_ticks = 16'd12;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        addr_pool[2] = 32'h0A00_0001;
        addr_pool[3] = 32'hC0A8_0001;
        for (int i = 4; i < 48; i++)
            addr_pool[i] = $urandom;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        configure(3'd4, 16'd2);
        queue_update(KIND_ADV, '0, '0, '0, addr_pool[0]);
        queue_update(KIND_RECV, addr_pool[2], FULL_MASK, 5'd1, addr_pool[4]);
        queue_update(KIND_RECV, addr_pool[8], FULL_MASK, 5'd16, addr_pool[4]);
        queue_update(KIND_RECV, addr_pool[8], FULL_MASK, 5'd31, addr_pool[4]);
        queue_update(KIND_RECV, addr_pool[8], 32'hFFFF_FF00, 5'd5, addr_pool[4]);
        queue_update(KIND_RECV, addr_pool[8], 32'hFFFF_0000, 5'd5, addr_pool[5]);
        queue_update(KIND_RECV, addr_pool[8], 32'h0000_0000, 5'd0, addr_pool[1]);
        queue_update(KIND_RECV, addr_pool[9], FULL_MASK, 5'd15, addr_pool[0]);
        queue_update(KIND_ADD, addr_pool[3], '0, '0, '0);
        queue_update(KIND_ADD, addr_pool[9], '0, '0, '0);
        queue_update(KIND_ADD, addr_pool[10], '0, '0, '0);
        queue_update(KIND_LOOKUP, addr_pool[8], '0, '0, '0);
        queue_update(KIND_LOOKUP, addr_pool[11], '0, '0, '0);
        queue_update(KIND_ADV, '0, '0, '0, addr_pool[1]);
        queue_update(KIND_ADV, '0, '0, '0, addr_pool[10]);
        queue_update(KIND_TICK, '0, '0, '0, '0);
        queue_update(KIND_TICK, FULL_MASK, FULL_MASK, 5'h1F, FULL_MASK);
        queue_update(KIND_TICK, '0, '0, '0, '0);
        queue_update(KIND_ADV, '0, '0, '0, addr_pool[0]);
        queue_update(KIND_REMOVE, addr_pool[10], '0, '0, '0);
        queue_update(KIND_REMOVE, addr_pool[12], '0, '0, '0);
        queue_update(3'd6, '0, '0, '0, '0);
        queue_update(3'd7, FULL_MASK, FULL_MASK, 5'h1F, FULL_MASK);
        queue_update(KIND_ADV, '0, '0, '0, addr_pool[0]);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: configure(3'd0, 16'd65534);
                1: configure(3'd1, 16'd1);
                2: configure(3'd3, 16'($urandom_range(30, 3)));
                default: configure(3'd4, 16'd65534);
            endcase
            idle_pct = (phase == 1) ? 50 : (phase == 3) ? 36 : 0;
            queue_random(50);
            drain();
        end

        $display("%0d updates sent, %0d results checked, %0d routes advertised,",
                 updates_sent, results_seen, routes_listed);
        $display("%0d inserts dropped on a full table, over five register settings",
                 full_drops);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
